[design/ppz_pkg.sv]
// Shared types and constants for the point projection block with depth buffer.
// No dependencies; imported by ppz_rdiv and point_projection_zbuffer_top.
package ppz_pkg;

  // Signed width of a projected row sum: 32x20 products, three of them plus an offset.
  localparam int NW = 54;
  // Signed width of one coefficient-by-coordinate product.
  localparam int PW = 52;
  // Quotient bits: any quotient of 512 or more is outside every legal image.
  localparam int QW = 9;

  // Depth, hit count and intensity share one memory word.
  localparam int DEPTH_W = 19;
  localparam int HITS_W  = 8;
  localparam int INT_W   = 16;
  localparam int ZW      = DEPTH_W + HITS_W + INT_W;

  // Intensity scaling: r * 65535 / 150 through a reciprocal with one correction step.
  localparam int REFL_SAT  = 100;
  localparam int INT_DIV   = 150;
  localparam int RECIP_K   = 27962;
  localparam int RECIP_SH  = 22;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_PROJ = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam logic [2:0] CFG_ROW0_L = 3'd0;
  localparam logic [2:0] CFG_ROW0_R = 3'd1;
  localparam logic [2:0] CFG_ROW1_L = 3'd2;
  localparam logic [2:0] CFG_ROW1_R = 3'd3;
  localparam logic [2:0] CFG_ROW2_L = 3'd4;
  localparam logic [2:0] CFG_ROW2_R = 3'd5;
  localparam logic [2:0] CFG_WIDTH  = 3'd6;
  localparam logic [2:0] CFG_HEIGHT = 3'd7;

  typedef struct packed {
    logic load;
    logic step;
  } ppz_div_ctl_t;

endpackage

[design/point_projection_zbuffer_top.sv]
// Top level of the point projection block with depth buffer.
// Depends on ppz_pkg and ppz_rdiv.
//
// Input channel in_valid/in_stall carries one item; kind selects loading a color
// pixel, projecting a point, or reading back one pixel's stores. Each item gives
// exactly one transaction on the out_valid/out_stall channel.
// One item is worked on at a time. A load or an unused kind goes straight to the
// output register, a read first through a memory read (an out-of-range read skips
// it), and a projected point through the three row multipliers, then the two
// restoring dividers (one quotient bit each cycle), then a check, a memory read and
// the depth update; a point that misses the image skips the read and the update.
// The result sits in an output register, so the next item is taken while it waits.
// A stalled output holds its payload; the block then finishes the current item and
// waits before overwriting the output register.
// After reset the depth, hit and intensity memory is cleared, one entry a cycle,
// over all 2**(row bits + column bits) entries (65536 at the default size); in_stall is
// high during that pass. Configuration writes are taken at any time.
module point_projection_zbuffer_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic signed [19:0] in_point_x,
  input  logic signed [19:0] in_point_y,
  input  logic signed [19:0] in_point_z,
  input  logic [7:0]  in_reflectivity,
  input  logic [7:0]  in_pixel_row,
  input  logic [7:0]  in_pixel_col,
  input  logic [7:0]  in_load_red,
  input  logic [7:0]  in_load_green,
  input  logic [7:0]  in_load_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_point_valid,
  output logic signed [19:0] out_out_x,
  output logic signed [19:0] out_out_y,
  output logic signed [19:0] out_out_z,
  output logic [7:0]  out_out_red,
  output logic [7:0]  out_out_green,
  output logic [7:0]  out_out_blue,
  output logic [7:0]  out_proj_row,
  output logic [7:0]  out_proj_col,
  output logic [18:0] out_depth_read,
  output logic [7:0]  out_hits_read,
  output logic [15:0] out_intensity_read
);
  import ppz_pkg::*;

  // Image sizes are at most 511, so nine address bits per axis cover every pixel.
  localparam int RW    = (MAX_HEIGHT >= 512) ? 9 : $clog2(MAX_HEIGHT);
  localparam int CW    = (MAX_WIDTH >= 512) ? 9 : $clog2(MAX_WIDTH);
  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;
  localparam logic [9:0]  WCAP = (MAX_WIDTH > 511) ? 10'd511 : 10'(MAX_WIDTH);
  localparam logic [9:0]  HCAP = (MAX_HEIGHT > 511) ? 10'd511 : 10'(MAX_HEIGHT);
  localparam logic [12:0] MAXW13 = 13'(MAX_WIDTH);
  localparam logic [12:0] MAXH13 = 13'(MAX_HEIGHT);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_MEM  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  // Configuration registers.
  logic [63:0] coef_r [6];
  logic [8:0]  image_width_r;
  logic [8:0]  image_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) coef_r[i] <= '0;
      image_width_r  <= 9'd256;
      image_height_r <= 9'd256;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ROW0_L: coef_r[0] <= cfg_data;
        CFG_ROW0_R: coef_r[1] <= cfg_data;
        CFG_ROW1_L: coef_r[2] <= cfg_data;
        CFG_ROW1_R: coef_r[3] <= cfg_data;
        CFG_ROW2_L: coef_r[4] <= cfg_data;
        CFG_ROW2_R: coef_r[5] <= cfg_data;
        CFG_WIDTH:  image_width_r  <= cfg_data[8:0];
        CFG_HEIGHT: image_height_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  logic [8:0] w_eff;
  logic [8:0] h_eff;
  assign w_eff = ({1'b0, image_width_r} < WCAP) ? image_width_r : WCAP[8:0];
  assign h_eff = ({1'b0, image_height_r} < HCAP) ? image_height_r : HCAP[8:0];

  // Sequencer and item registers.
  logic [2:0] state_r, state_nxt;
  logic       clr_r;
  logic [AW-1:0] clr_addr_r;
  logic [1:0] kind_r;
  logic signed [19:0] px_r, py_r, pz_r;
  logic [7:0] refl_r;
  logic [AW-1:0] pix_addr_r;
  logic [1:0] mul_cnt_r;
  logic [3:0] step_cnt_r;

  logic accept;
  logic in_addr_ok;
  logic [AW-1:0] in_addr;

  assign in_stall   = clr_r || (state_r != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign in_addr_ok = (13'(in_pixel_row) < MAXH13) && (13'(in_pixel_col) < MAXW13);
  assign in_addr    = {RW'(in_pixel_row), CW'(in_pixel_col)};

  // Row sums: one multiplier per matrix row, one coordinate per cycle.
  logic signed [NW-1:0] acc_r  [3];
  logic signed [PW-1:0] prod_r [3];
  logic signed [31:0]   mcoef  [3];
  logic signed [19:0]   mcoord;

  always_comb begin
    unique case (mul_cnt_r)
      2'd0: mcoord = px_r;
      2'd1: mcoord = py_r;
      2'd2: mcoord = pz_r;
      default: mcoord = '0;
    endcase
    for (int r = 0; r < 3; r++) begin
      unique case (mul_cnt_r)
        2'd0: mcoef[r] = coef_r[2*r][63:32];
        2'd1: mcoef[r] = coef_r[2*r][31:0];
        2'd2: mcoef[r] = coef_r[2*r+1][63:32];
        default: mcoef[r] = '0;
      endcase
    end
  end

  // Intensity through reciprocal multiply and a single correction.
  logic [23:0] int_p;
  logic [38:0] int_prod;
  logic [15:0] int_q0_r;
  logic [23:0] int_rem;
  logic [15:0] int_r;
  assign int_p    = (24'(refl_r) << 16) - 24'(refl_r);
  assign int_prod = 39'(int_p) * 39'(RECIP_K);
  assign int_rem  = int_p - 24'(int_q0_r) * 24'(INT_DIV);

  // Sign-normalized numerators and divisor.
  logic signed [NW-1:0] num_a, num_b, den_d;
  logic pre_ok_r;
  assign den_d = acc_r[2][NW-1] ? -acc_r[2] : acc_r[2];
  assign num_a = acc_r[2][NW-1] ? -acc_r[0] : acc_r[0];
  assign num_b = acc_r[2][NW-1] ? -acc_r[1] : acc_r[1];

  ppz_div_ctl_t div_ctl;
  logic [QW-1:0] qa, qb;
  logic rnd_a, rnd_b, ovf_a, ovf_b;
  assign div_ctl.load = (state_r == S_PREP);
  assign div_ctl.step = (state_r == S_DIV);

  ppz_rdiv u_div_col (
    .clk(clk), .ctl(div_ctl), .num(num_a), .den(den_d),
    .quot(qa), .round_up(rnd_a), .overflow(ovf_a)
  );
  ppz_rdiv u_div_row (
    .clk(clk), .ctl(div_ctl), .num(num_b), .den(den_d),
    .quot(qb), .round_up(rnd_b), .overflow(ovf_b)
  );

  logic [9:0] col_c, row_c;
  logic       in_view;
  assign col_c   = 10'(qa) + 10'(rnd_a);
  assign row_c   = 10'(qb) + 10'(rnd_b);
  assign in_view = pre_ok_r && !ovf_a && !ovf_b &&
                   (10'(qa) < 10'(w_eff)) && (10'(qb) < 10'(h_eff)) &&
                   (col_c < 10'(w_eff)) && (row_c < 10'(h_eff));

  // Memories.
  logic [23:0]   colour_mem [DEPTH];
  logic [ZW-1:0] z_mem      [DEPTH];
  logic [23:0]   colour_q_r;
  logic [ZW-1:0] z_q_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          col_we;
  logic          z_we;
  logic [AW-1:0] z_wa;
  logic [ZW-1:0] z_wd;

  logic [DEPTH_W-1:0] z_depth;
  logic [HITS_W-1:0]  z_hits;
  logic               z_upd;
  logic [HITS_W-1:0]  hits_inc;
  logic [INT_W-1:0]   int_val;

  assign z_depth  = z_q_r[ZW-1 -: DEPTH_W];
  assign z_hits   = z_q_r[INT_W +: HITS_W];
  assign z_upd    = (z_depth == '0) || (px_r[DEPTH_W-1:0] < z_depth);
  assign hits_inc = (z_hits == '1) ? z_hits : z_hits + 1'b1;
  assign int_val  = (refl_r > 8'(REFL_SAT)) ? '1 : int_r;

  assign col_we  = accept && (in_kind == KIND_LOAD) && in_addr_ok;
  assign rd_en   = (accept && (in_kind == KIND_READ) && in_addr_ok) ||
                   ((state_r == S_CHK) && in_view);
  assign rd_addr = (state_r == S_CHK) ? {row_c[RW-1:0], col_c[CW-1:0]} : in_addr;

  always_comb begin
    z_we = 1'b0;
    z_wa = pix_addr_r;
    z_wd = {px_r[DEPTH_W-1:0], hits_inc, int_val};
    if (clr_r) begin
      z_we = 1'b1;
      z_wa = clr_addr_r;
      z_wd = '0;
    end else if ((state_r == S_MEM) && (kind_r == KIND_PROJ) && z_upd) begin
      z_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (col_we) colour_mem[in_addr] <= {in_load_red, in_load_green, in_load_blue};
    if (rd_en)  colour_q_r <= colour_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (z_we)  z_mem[z_wa] <= z_wd;
    if (rd_en) z_q_r <= z_mem[rd_addr];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_PROJ) state_nxt = S_MUL;
          else if (in_kind == KIND_READ && in_addr_ok) state_nxt = S_MEM;
          else state_nxt = S_DONE;
        end
      end
      S_MUL:  if (mul_cnt_r == 2'd3) state_nxt = S_PREP;
      S_PREP: state_nxt = S_DIV;
      S_DIV:  if (step_cnt_r == 4'(QW - 1)) state_nxt = S_CHK;
      S_CHK:  state_nxt = in_view ? S_MEM : S_DONE;
      S_MEM:  state_nxt = S_DONE;
      S_DONE: if (!out_valid || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result staging.
  logic       res_pv_r;
  logic [23:0] res_rgb_r;
  logic [7:0]  res_row_r, res_col_r;
  logic [18:0] res_depth_r;
  logic [7:0]  res_hits_r;
  logic [15:0] res_int_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (&clr_addr_r) clr_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r      <= in_kind;
      px_r        <= in_point_x;
      py_r        <= in_point_y;
      pz_r        <= in_point_z;
      refl_r      <= in_reflectivity;
      pix_addr_r  <= in_addr;
      mul_cnt_r   <= '0;
      step_cnt_r  <= '0;
      res_pv_r    <= 1'b0;
      res_rgb_r   <= '0;
      res_row_r   <= '0;
      res_col_r   <= '0;
      res_depth_r <= '0;
      res_hits_r  <= '0;
      res_int_r   <= '0;
      for (int r = 0; r < 3; r++) acc_r[r] <= NW'($signed(coef_r[2*r+1][31:0]));
    end
    unique case (state_r)
      S_MUL: begin
        for (int r = 0; r < 3; r++) begin
          prod_r[r] <= PW'(mcoef[r]) * PW'(mcoord);
          if (mul_cnt_r != 2'd0) acc_r[r] <= acc_r[r] + NW'(prod_r[r]);
        end
        if (mul_cnt_r == 2'd0) int_q0_r <= int_prod[RECIP_SH +: INT_W];
        mul_cnt_r <= mul_cnt_r + 2'd1;
      end
      S_PREP: begin
        pre_ok_r <= !px_r[19] && (acc_r[2] != '0) && !num_a[NW-1] && !num_b[NW-1];
        int_r    <= (int_rem >= 24'(INT_DIV)) ? int_q0_r + 16'd1 : int_q0_r;
      end
      S_DIV: step_cnt_r <= step_cnt_r + 4'd1;
      S_CHK: begin
        // A point outside the image reports row and column as zero.
        pix_addr_r <= {row_c[RW-1:0], col_c[CW-1:0]};
        res_row_r  <= in_view ? row_c[7:0] : '0;
        res_col_r  <= in_view ? col_c[7:0] : '0;
        res_pv_r   <= in_view;
      end
      S_MEM: begin
        res_rgb_r <= colour_q_r;
        if (kind_r == KIND_READ) begin
          res_depth_r <= z_depth;
          res_hits_r  <= z_hits;
          res_int_r   <= z_q_r[INT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Output register.
  logic out_valid_r;
  logic load_out;
  logic is_proj;
  assign load_out = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign is_proj  = (kind_r == KIND_PROJ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_point_valid    <= res_pv_r;
      out_out_x          <= is_proj ? px_r : '0;
      out_out_y          <= is_proj ? py_r : '0;
      out_out_z          <= is_proj ? pz_r : '0;
      out_out_red        <= res_rgb_r[23:16];
      out_out_green      <= res_rgb_r[15:8];
      out_out_blue       <= res_rgb_r[7:0];
      out_proj_row       <= res_row_r;
      out_proj_col       <= res_col_r;
      out_depth_read     <= res_depth_r;
      out_hits_read      <= res_hits_r;
      out_intensity_read <= res_int_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[design/ppz_rdiv.sv]
// Restoring divider, one quotient bit per step cycle, round-half-up, overflow flag.
// Depends on ppz_pkg.
module ppz_rdiv (
  input  logic                    clk,
  input  ppz_pkg::ppz_div_ctl_t   ctl,
  input  logic [ppz_pkg::NW-1:0]  num,
  input  logic [ppz_pkg::NW-1:0]  den,
  output logic [ppz_pkg::QW-1:0]  quot,
  output logic                    round_up,
  output logic                    overflow
);
  import ppz_pkg::*;

  localparam int TW = NW + QW;

  logic [NW-1:0] rem_r;
  logic [NW-1:0] den_r;
  logic [QW-1:0] q_r;
  logic [3:0]    cnt_r;
  logic          ovf_r;
  logic [TW-1:0] trial;
  logic          fits;

  assign trial = TW'(den_r) << cnt_r;
  assign fits  = TW'(rem_r) >= trial;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem_r <= num;
      den_r <= den;
      q_r   <= '0;
      cnt_r <= 4'(QW - 1);
      ovf_r <= TW'(num) >= (TW'(den) << QW);
    end else if (ctl.step) begin
      if (fits) begin
        rem_r        <= rem_r - trial[NW-1:0];
        q_r[cnt_r]   <= 1'b1;
      end
      cnt_r <= cnt_r - 4'd1;
    end
  end

  assign quot     = q_r;
  assign round_up = {rem_r, 1'b0} >= {1'b0, den_r};
  assign overflow = ovf_r;

endmodule
